/* rtl/core/sst_pkg.sv */
// package for the scoped symbol table: widths, codes, entry and beat types
// no dependencies
package sst_pkg;

    localparam int MAX_SCOPES     = 256;
    localparam int MAX_SYMBOLS    = 1024;
    localparam int MAX_CANDIDATES = 1024;

    localparam int SCOPE_W = $clog2(MAX_SCOPES);
    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int CAND_W  = $clog2(MAX_CANDIDATES);
    localparam int SCNT_W  = SCOPE_W + 1;
    localparam int YCNT_W  = SYM_W + 1;
    localparam int CCNT_W  = CAND_W + 1;

    localparam logic [3:0] K_OPEN      = 4'd0;
    localparam logic [3:0] K_DECLARE   = 4'd1;
    localparam logic [3:0] K_FIND      = 4'd2;
    localparam logic [3:0] K_SET_TYPE  = 4'd3;
    localparam logic [3:0] K_SET_SUPER = 4'd4;
    localparam logic [3:0] K_OWNER     = 4'd5;
    localparam logic [3:0] K_NODE      = 4'd6;
    localparam logic [3:0] K_RD_SCOPE  = 4'd7;
    localparam logic [3:0] K_RD_SYM    = 4'd8;
    localparam logic [3:0] K_RD_CAND   = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  scope_index;
        logic [7:0]  parent_scope;
        logic [15:0] name_id;
        logic [7:0]  symbol_kind;
        logic [31:0] node_id;
        logic [9:0]  symbol_index;
        logic [9:0]  candidate_index;
        logic [31:0] type_value;
        logic [31:0] super_value;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  result_index;
        logic [1:0]  status;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [31:0] word_e;
        logic [8:0]  scope_total;
        logic [10:0] symbol_total;
        logic [10:0] candidate_total;
    } rsp_t;

    typedef struct packed {
        logic [SCOPE_W-1:0] parent;
        logic [SYM_W-1:0]   first;
        logic [31:0]        owner;
    } scope_ent_t;

    typedef struct packed {
        logic [15:0]       name;
        logic [SYM_W-1:0]  next;
        logic [CAND_W-1:0] first;
    } sym_ent_t;

    typedef struct packed {
        logic [7:0]        kind;
        logic [31:0]       node;
        logic [31:0]       typ;
        logic [31:0]       sup;
        logic [CAND_W-1:0] next;
    } cand_ent_t;

    typedef struct packed {
        logic               scope_we;
        logic [SCOPE_W-1:0] scope_waddr;
        scope_ent_t         scope_wdata;
        logic [SCOPE_W-1:0] scope_raddr;
        logic               sym_we;
        logic [SYM_W-1:0]   sym_waddr;
        sym_ent_t           sym_wdata;
        logic [SYM_W-1:0]   sym_raddr;
        logic               cand_we;
        logic [CAND_W-1:0]  cand_waddr;
        cand_ent_t          cand_wdata;
        logic [CAND_W-1:0]  cand_raddr;
    } mem_req_t;

    typedef struct packed {
        scope_ent_t scope_q;
        sym_ent_t   sym_q;
        cand_ent_t  cand_q;
    } mem_rd_t;

endpackage

/* rtl/core/sst_tables.sv */
// scope, symbol and candidate tables, one write and one registered read each
// depends on sst_pkg
module sst_tables (
    input  logic              clk,
    input  sst_pkg::mem_req_t req,
    output sst_pkg::mem_rd_t  rd
);
    import sst_pkg::*;

    scope_ent_t scope_mem [MAX_SCOPES];
    sym_ent_t   sym_mem   [MAX_SYMBOLS];
    cand_ent_t  cand_mem  [MAX_CANDIDATES];

    always_ff @(posedge clk)
    begin
        if (req.scope_we)
        begin
            scope_mem[req.scope_waddr] <= req.scope_wdata;
        end
        if (req.sym_we)
        begin
            sym_mem[req.sym_waddr] <= req.sym_wdata;
        end
        if (req.cand_we)
        begin
            cand_mem[req.cand_waddr] <= req.cand_wdata;
        end
        rd.scope_q <= scope_mem[req.scope_raddr];
        rd.sym_q   <= sym_mem[req.sym_raddr];
        rd.cand_q  <= cand_mem[req.cand_raddr];
    end

endmodule

/* rtl/core/sst_ctrl.sv */
// sequencer for the scoped symbol table: decode, chain walks, searches, counts
// depends on sst_pkg and drives the table memories in sst_tables
module sst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sst_pkg::cmd_t     request,
    output logic              busy,
    output logic              done,
    output sst_pkg::rsp_t     response,
    output sst_pkg::mem_req_t req,
    input  sst_pkg::mem_rd_t  rd
);
    import sst_pkg::*;

    localparam logic [4:0] S_INIT0      = 5'd0;
    localparam logic [4:0] S_INIT1      = 5'd1;
    localparam logic [4:0] S_IDLE       = 5'd2;
    localparam logic [4:0] S_DECODE     = 5'd3;
    localparam logic [4:0] S_SCOPE_WAIT = 5'd4;
    localparam logic [4:0] S_LK_TEST    = 5'd5;
    localparam logic [4:0] S_LK_CHK     = 5'd6;
    localparam logic [4:0] S_LK_END     = 5'd7;
    localparam logic [4:0] S_LINK_SYM   = 5'd8;
    localparam logic [4:0] S_CAND_START = 5'd9;
    localparam logic [4:0] S_LINK_FIRST = 5'd10;
    localparam logic [4:0] S_CW_RD      = 5'd11;
    localparam logic [4:0] S_CW_CHK     = 5'd12;
    localparam logic [4:0] S_CAND_WAIT  = 5'd13;
    localparam logic [4:0] S_READ_WAIT  = 5'd14;
    localparam logic [4:0] S_OWN_RD     = 5'd15;
    localparam logic [4:0] S_OWN_CHK    = 5'd16;
    localparam logic [4:0] S_NODE_RD    = 5'd17;
    localparam logic [4:0] S_NODE_CHK   = 5'd18;

    logic [4:0]        state_reg, state_next;
    cmd_t              item_reg, item_next;
    logic [SCNT_W-1:0] scope_used_reg, scope_used_next;
    logic [YCNT_W-1:0] symbol_used_reg, symbol_used_next;
    logic [CCNT_W-1:0] cand_used_reg, cand_used_next;
    logic [SYM_W-1:0]  s_reg, s_next;
    logic [SYM_W-1:0]  prev_reg, prev_next;
    logic [CAND_W-1:0] l_reg, l_next;
    logic [CAND_W-1:0] c_reg, c_next;
    logic [CCNT_W-1:0] i_reg, i_next;
    logic              found_reg, found_next;
    scope_ent_t        scope_word_reg, scope_word_next;
    sym_ent_t          sym_word_reg, sym_word_next;
    sym_ent_t          prev_word_reg, prev_word_next;
    rsp_t              out_reg, out_next;
    logic              done_reg, done_next;

    logic        fin;
    logic [9:0]  fin_res;
    logic [1:0]  fin_st;
    logic [31:0] fin_a, fin_b, fin_c, fin_d, fin_e;

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        scope_used_next  = scope_used_reg;
        symbol_used_next = symbol_used_reg;
        cand_used_next   = cand_used_reg;
        s_next           = s_reg;
        prev_next        = prev_reg;
        l_next           = l_reg;
        c_next           = c_reg;
        i_next           = i_reg;
        found_next       = found_reg;
        scope_word_next  = scope_word_reg;
        sym_word_next    = sym_word_reg;
        prev_word_next   = prev_word_reg;
        out_next         = out_reg;
        req              = '0;
        fin              = 1'b0;
        fin_res          = '0;
        fin_st           = ST_OK;
        fin_a            = '0;
        fin_b            = '0;
        fin_c            = '0;
        fin_d            = '0;
        fin_e            = '0;

        case (state_reg)
            S_INIT0:
            begin
                // sentinels
                req.scope_we = 1'b1;
                req.sym_we   = 1'b1;
                req.cand_we  = 1'b1;
                state_next   = S_INIT1;
            end
            S_INIT1:
            begin
                // module scope
                req.scope_we    = 1'b1;
                req.scope_waddr = SCOPE_W'(1);
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = request;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (item_reg.kind)
                    K_OPEN:
                    begin
                        fin = 1'b1;
                        if (SCNT_W'(item_reg.parent_scope) >= scope_used_reg)
                        begin
                            fin_st = ST_RANGE;
                        end
                        else if (scope_used_reg >= SCNT_W'(MAX_SCOPES))
                        begin
                            fin_st = ST_FULL;
                        end
                        else
                        begin
                            req.scope_we           = 1'b1;
                            req.scope_waddr        = scope_used_reg[SCOPE_W-1:0];
                            req.scope_wdata.parent = item_reg.parent_scope;
                            req.scope_wdata.first  = '0;
                            req.scope_wdata.owner  = item_reg.node_id;
                            fin_res         = 10'(scope_used_reg[SCOPE_W-1:0]);
                            scope_used_next = scope_used_reg + 1'b1;
                        end
                    end
                    K_DECLARE, K_FIND:
                    begin
                        if ((item_reg.kind == K_DECLARE && item_reg.scope_index == '0) ||
                            SCNT_W'(item_reg.scope_index) >= scope_used_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_RANGE;
                        end
                        else
                        begin
                            req.scope_raddr = item_reg.scope_index;
                            state_next      = S_SCOPE_WAIT;
                        end
                    end
                    K_SET_TYPE, K_SET_SUPER, K_RD_CAND:
                    begin
                        if ((item_reg.kind != K_RD_CAND && item_reg.candidate_index == '0) ||
                            CCNT_W'(item_reg.candidate_index) >= cand_used_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_RANGE;
                        end
                        else
                        begin
                            req.cand_raddr = item_reg.candidate_index;
                            state_next     = S_CAND_WAIT;
                        end
                    end
                    K_OWNER:
                    begin
                        i_next     = CCNT_W'(1);
                        state_next = S_OWN_RD;
                    end
                    K_NODE:
                    begin
                        i_next = CCNT_W'(1);
                        if (cand_used_reg > CCNT_W'(1))
                        begin
                            state_next = S_NODE_RD;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    K_RD_SCOPE:
                    begin
                        if (SCNT_W'(item_reg.scope_index) >= scope_used_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_RANGE;
                        end
                        else
                        begin
                            req.scope_raddr = item_reg.scope_index;
                            state_next      = S_READ_WAIT;
                        end
                    end
                    K_RD_SYM:
                    begin
                        if (YCNT_W'(item_reg.symbol_index) >= symbol_used_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_RANGE;
                        end
                        else
                        begin
                            req.sym_raddr = item_reg.symbol_index;
                            state_next    = S_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_SCOPE_WAIT:
            begin
                scope_word_next = rd.scope_q;
                s_next          = rd.scope_q.first;
                prev_next       = '0;
                found_next      = 1'b0;
                state_next      = S_LK_TEST;
            end
            S_LK_TEST:
            begin
                if (s_reg != '0 && YCNT_W'(s_reg) < symbol_used_reg)
                begin
                    req.sym_raddr = s_reg;
                    state_next    = S_LK_CHK;
                end
                else
                begin
                    state_next = S_LK_END;
                end
            end
            S_LK_CHK:
            begin
                if (rd.sym_q.name == item_reg.name_id)
                begin
                    found_next    = 1'b1;
                    sym_word_next = rd.sym_q;
                    state_next    = S_LK_END;
                end
                else
                begin
                    prev_next      = s_reg;
                    prev_word_next = rd.sym_q;
                    s_next         = rd.sym_q.next;
                    state_next     = S_LK_TEST;
                end
            end
            S_LK_END:
            begin
                if (item_reg.kind == K_FIND)
                begin
                    fin     = 1'b1;
                    fin_res = found_reg ? 10'(s_reg) : '0;
                end
                else if (cand_used_reg >= CCNT_W'(MAX_CANDIDATES) ||
                         (!found_reg && symbol_used_reg >= YCNT_W'(MAX_SYMBOLS)))
                begin
                    fin    = 1'b1;
                    fin_st = ST_FULL;
                end
                else if (!found_reg)
                begin
                    req.sym_we          = 1'b1;
                    req.sym_waddr       = symbol_used_reg[SYM_W-1:0];
                    req.sym_wdata.name  = item_reg.name_id;
                    req.sym_wdata.next  = '0;
                    req.sym_wdata.first = '0;
                    sym_word_next       = req.sym_wdata;
                    s_next              = symbol_used_reg[SYM_W-1:0];
                    symbol_used_next    = symbol_used_reg + 1'b1;
                    state_next          = S_LINK_SYM;
                end
                else
                begin
                    state_next = S_CAND_START;
                end
            end
            S_LINK_SYM:
            begin
                if (prev_reg == '0)
                begin
                    req.scope_we          = 1'b1;
                    req.scope_waddr       = item_reg.scope_index;
                    req.scope_wdata       = scope_word_reg;
                    req.scope_wdata.first = s_reg;
                end
                else
                begin
                    req.sym_we         = 1'b1;
                    req.sym_waddr      = prev_reg;
                    req.sym_wdata      = prev_word_reg;
                    req.sym_wdata.next = s_reg;
                end
                state_next = S_CAND_START;
            end
            S_CAND_START:
            begin
                req.cand_we         = 1'b1;
                req.cand_waddr      = cand_used_reg[CAND_W-1:0];
                req.cand_wdata.kind = item_reg.symbol_kind;
                req.cand_wdata.node = item_reg.node_id;
                req.cand_wdata.typ  = '0;
                req.cand_wdata.sup  = '0;
                req.cand_wdata.next = '0;
                c_next              = cand_used_reg[CAND_W-1:0];
                cand_used_next      = cand_used_reg + 1'b1;
                l_next              = sym_word_reg.first;
                state_next          = (sym_word_reg.first == '0) ? S_LINK_FIRST : S_CW_RD;
            end
            S_LINK_FIRST:
            begin
                req.sym_we          = 1'b1;
                req.sym_waddr       = s_reg;
                req.sym_wdata       = sym_word_reg;
                req.sym_wdata.first = c_reg;
                fin                 = 1'b1;
                fin_res             = 10'(s_reg);
            end
            S_CW_RD:
            begin
                req.cand_raddr = l_reg;
                state_next     = S_CW_CHK;
            end
            S_CW_CHK:
            begin
                if (rd.cand_q.next != '0)
                begin
                    l_next     = rd.cand_q.next;
                    state_next = S_CW_RD;
                end
                else
                begin
                    req.cand_we         = 1'b1;
                    req.cand_waddr      = l_reg;
                    req.cand_wdata      = rd.cand_q;
                    req.cand_wdata.next = c_reg;
                    fin                 = 1'b1;
                    fin_res             = 10'(s_reg);
                end
            end
            S_CAND_WAIT:
            begin
                fin     = 1'b1;
                fin_res = 10'(item_reg.candidate_index);
                if (item_reg.kind == K_RD_CAND)
                begin
                    fin_a = 32'(rd.cand_q.kind);
                    fin_b = rd.cand_q.node;
                    fin_c = rd.cand_q.typ;
                    fin_d = rd.cand_q.sup;
                    fin_e = 32'(rd.cand_q.next);
                end
                else
                begin
                    req.cand_we    = 1'b1;
                    req.cand_waddr = item_reg.candidate_index;
                    req.cand_wdata = rd.cand_q;
                    if (item_reg.kind == K_SET_TYPE)
                    begin
                        req.cand_wdata.typ = item_reg.type_value;
                    end
                    else
                    begin
                        req.cand_wdata.sup = item_reg.super_value;
                    end
                end
            end
            S_READ_WAIT:
            begin
                fin = 1'b1;
                if (item_reg.kind == K_RD_SCOPE)
                begin
                    fin_res = 10'(item_reg.scope_index);
                    fin_a   = 32'(rd.scope_q.parent);
                    fin_b   = 32'(rd.scope_q.first);
                    fin_c   = rd.scope_q.owner;
                end
                else
                begin
                    fin_res = 10'(item_reg.symbol_index);
                    fin_a   = 32'(rd.sym_q.name);
                    fin_b   = 32'(rd.sym_q.next);
                    fin_c   = 32'(rd.sym_q.first);
                end
            end
            S_OWN_RD:
            begin
                req.scope_raddr = i_reg[SCOPE_W-1:0];
                state_next      = S_OWN_CHK;
            end
            S_OWN_CHK:
            begin
                if (rd.scope_q.owner == item_reg.node_id)
                begin
                    fin     = 1'b1;
                    fin_res = 10'(i_reg[SCOPE_W-1:0]);
                end
                else if (i_reg + 1'b1 < CCNT_W'(scope_used_reg))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OWN_RD;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_NODE_RD:
            begin
                req.cand_raddr = i_reg[CAND_W-1:0];
                state_next     = S_NODE_CHK;
            end
            S_NODE_CHK:
            begin
                if (rd.cand_q.node == item_reg.node_id)
                begin
                    fin     = 1'b1;
                    fin_res = 10'(i_reg[CAND_W-1:0]);
                end
                else if (i_reg + 1'b1 < cand_used_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_NODE_RD;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next = fin;
        if (fin)
        begin
            state_next               = S_IDLE;
            out_next.result_index    = fin_res;
            out_next.status          = fin_st;
            out_next.word_a          = fin_a;
            out_next.word_b          = fin_b;
            out_next.word_c          = fin_c;
            out_next.word_d          = fin_d;
            out_next.word_e          = fin_e;
            out_next.scope_total     = 9'(scope_used_next);
            out_next.symbol_total    = 11'(symbol_used_next);
            out_next.candidate_total = 11'(cand_used_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT0;
            scope_used_reg  <= SCNT_W'(2);
            symbol_used_reg <= YCNT_W'(1);
            cand_used_reg   <= CCNT_W'(1);
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scope_used_reg  <= scope_used_next;
            symbol_used_reg <= symbol_used_next;
            cand_used_reg   <= cand_used_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        s_reg          <= s_next;
        prev_reg       <= prev_next;
        l_reg          <= l_next;
        c_reg          <= c_next;
        i_reg          <= i_next;
        found_reg      <= found_next;
        scope_word_reg <= scope_word_next;
        sym_word_reg   <= sym_word_next;
        prev_word_reg  <= prev_word_next;
        out_reg        <= out_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = out_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result beat without an operation in flight");
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        scope_used_reg <= SCNT_W'(MAX_SCOPES) && symbol_used_reg <= YCNT_W'(MAX_SYMBOLS) &&
        cand_used_reg <= CCNT_W'(MAX_CANDIDATES))
        else $error("table count beyond capacity");
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !req.scope_we && !req.sym_we && !req.cand_we)
        else $error("table write while idle");
    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        start && state_reg == S_IDLE |=> state_reg == S_DECODE)
        else $error("accepted command not decoded");

endmodule

/* rtl/core/scoped_symbol_table_unit.sv */
// top level of the scoped symbol table: sequencer plus table memories
// depends on sst_pkg, sst_tables and sst_ctrl
//
// usage
//   a command beat is taken at a rising edge with start high and busy low
//   exactly one response beat follows, shown for one cycle with done high
//   the receiver cannot stall: done is a one-cycle strobe
// work per command
//   open, unused kinds and range errors: answered from decode
//   set type / super and reads: one table read, then the answer or the write-back
//   find: walks the symbol chain of the scope until a hit or the chain end
//   declare, new name: the find walk, then a new symbol linked in and its candidate
//   declare, known name: the find walk, then a walk of the candidate chain on the symbol
//   owner scope / node candidate: a linear search, up to 255 / 1023 entries
// the walk rate is set by one read a cycle on each table memory, each
//   result registered in sst_tables
// reset
//   counts go to two scopes, one symbol, one candidate; an init pass (S_INIT0,
//   then S_INIT1) then writes the zero sentinels and the module scope, busy high
module scoped_symbol_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sst_pkg::cmd_t request,
    output logic          busy,
    output logic          done,
    output sst_pkg::rsp_t response
);
    import sst_pkg::*;

    mem_req_t req;
    mem_rd_t  rd;

    sst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response),
        .req      (req),
        .rd       (rd)
    );

    sst_tables u_tables (
        .clk (clk),
        .req (req),
        .rd  (rd)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for scoped_symbol_table_unit: directed, random and scope-fill command beats
// depends on sst_pkg and the unit; results checked against a table predictor kept here
module testbench;
    import sst_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  start;
    cmd_t  request;
    logic  busy;
    logic  done;
    rsp_t  response;

    scoped_symbol_table_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    // predictor state
    logic [7:0]  sc_parent [MAX_SCOPES];
    logic [9:0]  sc_first  [MAX_SCOPES];
    logic [31:0] sc_owner  [MAX_SCOPES];
    logic [15:0] sy_name   [MAX_SYMBOLS];
    logic [9:0]  sy_next   [MAX_SYMBOLS];
    logic [9:0]  sy_first  [MAX_SYMBOLS];
    logic [7:0]  cd_kind   [MAX_CANDIDATES];
    logic [31:0] cd_node   [MAX_CANDIDATES];
    logic [31:0] cd_type   [MAX_CANDIDATES];
    logic [31:0] cd_super  [MAX_CANDIDATES];
    logic [9:0]  cd_next   [MAX_CANDIDATES];
    int          scopes_used;
    int          symbols_used;
    int          cands_used;

    cmd_t cmd_q[$];
    rsp_t rsp_exp_q[$];
    int   errors;
    int   beats_in;
    int   quiet_cycles;
    bit   fired;

    task automatic queue_cmd(input cmd_t c);
        cmd_q = {cmd_q, c};
    endtask

    function automatic int find_name(int scope, logic [15:0] name);
        int s;
        int steps;
        s = int'(sc_first[scope]);
        steps = 0;
        while (s != 0 && s < symbols_used && steps < MAX_SYMBOLS) begin
            if (sy_name[s] == name)
                return s;
            s = int'(sy_next[s]);
            steps++;
        end
        return 0;
    endfunction

    task automatic predict_table_op(input cmd_t c, output rsp_t r);
        int s;
        int cd;
        int last;
        int steps;
        r = '0;
        r.status = ST_OK;
        case (c.kind)
            K_OPEN:
                if (c.parent_scope >= scopes_used)
                    r.status = ST_RANGE;
                else if (scopes_used >= MAX_SCOPES)
                    r.status = ST_FULL;
                else
                begin
                    r.result_index = 10'(scopes_used);
                    sc_parent[scopes_used] = c.parent_scope;
                    sc_first[scopes_used] = '0;
                    sc_owner[scopes_used] = c.node_id;
                    scopes_used++;
                end
            K_DECLARE:
            begin
                if (c.scope_index == 0 || c.scope_index >= scopes_used)
                    r.status = ST_RANGE;
                else
                begin
                    s = find_name(int'(c.scope_index), c.name_id);
                    if (cands_used >= MAX_CANDIDATES || (s == 0 && symbols_used >= MAX_SYMBOLS))
                        r.status = ST_FULL;
                    else
                    begin
                        if (s == 0)
                        begin
                            s = symbols_used;
                            symbols_used++;
                            sy_name[s] = c.name_id;
                            sy_next[s] = '0;
                            sy_first[s] = '0;
                            last = int'(sc_first[c.scope_index]);
                            if (last == 0)
                                sc_first[c.scope_index] = 10'(s);
                            else
                            begin
                                steps = 0;
                                while (sy_next[last] != 0 && steps < MAX_SYMBOLS)
                                begin
                                    last = int'(sy_next[last]);
                                    steps++;
                                end
                                sy_next[last] = 10'(s);
                            end
                        end
                        cd = cands_used;
                        cands_used++;
                        cd_kind[cd] = c.symbol_kind;
                        cd_node[cd] = c.node_id;
                        cd_type[cd] = '0;
                        cd_super[cd] = '0;
                        cd_next[cd] = '0;
                        last = int'(sy_first[s]);
                        if (last == 0)
                            sy_first[s] = 10'(cd);
                        else
                        begin
                            steps = 0;
                            while (cd_next[last] != 0 && steps < MAX_CANDIDATES)
                            begin
                                last = int'(cd_next[last]);
                                steps++;
                            end
                            cd_next[last] = 10'(cd);
                        end
                        r.result_index = 10'(s);
                    end
                end
            end
            K_FIND:
                if (c.scope_index >= scopes_used)
                    r.status = ST_RANGE;
                else
                    r.result_index = 10'(find_name(int'(c.scope_index), c.name_id));
            K_SET_TYPE, K_SET_SUPER:
                if (c.candidate_index == 0 || c.candidate_index >= cands_used)
                    r.status = ST_RANGE;
                else
                begin
                    if (c.kind == K_SET_TYPE)
                        cd_type[c.candidate_index] = c.type_value;
                    else
                        cd_super[c.candidate_index] = c.super_value;
                    r.result_index = c.candidate_index;
                end
            K_OWNER:
                for (int i = 1; i < scopes_used; i++)
                    if (sc_owner[i] == c.node_id)
                    begin
                        r.result_index = 10'(i);
                        break;
                    end
            K_NODE:
                for (int i = 1; i < cands_used; i++)
                    if (cd_node[i] == c.node_id)
                    begin
                        r.result_index = 10'(i);
                        break;
                    end
            K_RD_SCOPE:
                if (c.scope_index >= scopes_used)
                    r.status = ST_RANGE;
                else
                begin
                    r.result_index = 10'(c.scope_index);
                    r.word_a = 32'(sc_parent[c.scope_index]);
                    r.word_b = 32'(sc_first[c.scope_index]);
                    r.word_c = sc_owner[c.scope_index];
                end
            K_RD_SYM:
                if (c.symbol_index >= symbols_used)
                    r.status = ST_RANGE;
                else
                begin
                    r.result_index = c.symbol_index;
                    r.word_a = 32'(sy_name[c.symbol_index]);
                    r.word_b = 32'(sy_next[c.symbol_index]);
                    r.word_c = 32'(sy_first[c.symbol_index]);
                end
            K_RD_CAND:
                if (c.candidate_index >= cands_used)
                    r.status = ST_RANGE;
                else
                begin
                    r.result_index = c.candidate_index;
                    r.word_a = 32'(cd_kind[c.candidate_index]);
                    r.word_b = cd_node[c.candidate_index];
                    r.word_c = cd_type[c.candidate_index];
                    r.word_d = cd_super[c.candidate_index];
                    r.word_e = 32'(cd_next[c.candidate_index]);
                end
            default:
                ;
        endcase
        r.scope_total = 9'(scopes_used);
        r.symbol_total = 11'(symbols_used);
        r.candidate_total = 11'(cands_used);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic cmd_t make_cmd(input logic [3:0] kind);
        cmd_t c;
        c = '0;
        c.kind = kind;
        return c;
    endfunction

    // random beat; mostly in-range indices and a small name pool so chains form
    function automatic cmd_t random_cmd(input int fill);
        cmd_t         c;
        int           roll;
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = bits[$bits(cmd_t)-1:0];
        roll = $urandom_range(0, 99);
        if (fill == 1)
            c.kind = K_OPEN;
        else if (fill == 2)
            c.kind = K_DECLARE;
        else if (roll < 12)
            c.kind = K_OPEN;
        else if (roll < 45)
            c.kind = K_DECLARE;
        else if (roll < 95)
            c.kind = 4'($urandom_range(2, 9));
        else
            c.kind = 4'($urandom_range(10, 15));
        if ($urandom_range(0, 99) < 85)
        begin
            c.scope_index = 8'($urandom_range(0, scopes_used));
            c.parent_scope = 8'($urandom_range(0, scopes_used - 1));
            c.name_id = 16'($urandom_range(0, 11));
            c.symbol_index = 10'($urandom_range(0, symbols_used));
            c.candidate_index = 10'($urandom_range(0, cands_used));
            if ($urandom_range(0, 1))
                c.node_id = 32'($urandom_range(0, 15));
        end
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || fired))
        begin
            if (cmd_q.size() != 0 && ((beats_in > 300 && beats_in < 420)
                                      || $urandom_range(0, 99) >= 29))
            begin
                request <= cmd_q.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        fired = 1'b0;
        if (rst_n)
        begin
            quiet_cycles++;
            if (done)
            begin
                quiet_cycles = 0;
                got = response;
                if (rsp_exp_q.size() == 0)
                begin
                    $display("unexpected result beat at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = rsp_exp_q.pop_front();
                    if (got.result_index !== want.result_index)
                        report_mismatch("result_index", 32'(got.result_index),
                                        32'(want.result_index));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.word_a !== want.word_a)
                        report_mismatch("word_a", got.word_a, want.word_a);
                    if (got.word_b !== want.word_b)
                        report_mismatch("word_b", got.word_b, want.word_b);
                    if (got.word_c !== want.word_c)
                        report_mismatch("word_c", got.word_c, want.word_c);
                    if (got.word_d !== want.word_d)
                        report_mismatch("word_d", got.word_d, want.word_d);
                    if (got.word_e !== want.word_e)
                        report_mismatch("word_e", got.word_e, want.word_e);
                    if (got.scope_total !== want.scope_total)
                        report_mismatch("scope_total", 32'(got.scope_total),
                                        32'(want.scope_total));
                    if (got.symbol_total !== want.symbol_total)
                        report_mismatch("symbol_total", 32'(got.symbol_total),
                                        32'(want.symbol_total));
                    if (got.candidate_total !== want.candidate_total)
                        report_mismatch("candidate_total", 32'(got.candidate_total),
                                        32'(want.candidate_total));
                end
            end
            if (start && !busy)
            begin
                predict_table_op(request, want);
                rsp_exp_q = {rsp_exp_q, want};
                beats_in++;
                quiet_cycles = 0;
                fired = 1'b1;
            end
            if (quiet_cycles > 20000)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        wait (cmd_q.size() == 0 && !start && rsp_exp_q.size() == 0);
    endtask

    task automatic queue_random(input int count, input int fill);
        for (int i = 0; i < count; i++)
        begin
            queue_cmd(random_cmd(fill));
            wait (cmd_q.size() < 4);
        end
    endtask

    initial
    begin
        cmd_t c;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        errors = 0;
        beats_in = 0;
        quiet_cycles = 0;
        fired = 1'b0;
        scopes_used = 2;
        symbols_used = 1;
        cands_used = 1;
        sc_parent[0] = '0; sc_first[0] = '0; sc_owner[0] = '0;
        sc_parent[1] = '0; sc_first[1] = '0; sc_owner[1] = '0;
        sy_name[0] = '0; sy_next[0] = '0; sy_first[0] = '0;
        cd_kind[0] = '0; cd_node[0] = '0; cd_type[0] = '0; cd_super[0] = '0; cd_next[0] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        c = make_cmd(K_OPEN); c.node_id = 32'hFFFF_FFFF; queue_cmd(c);
        c = make_cmd(K_OPEN); c.parent_scope = 8'hFF; queue_cmd(c);
        c = make_cmd(K_OPEN); c.parent_scope = 8'd2; c.node_id = 32'h1; queue_cmd(c);
        c = make_cmd(K_DECLARE); queue_cmd(c);
        c = make_cmd(K_DECLARE); c.scope_index = 8'hFF; queue_cmd(c);
        c = make_cmd(K_DECLARE); c.scope_index = 8'd1; c.name_id = 16'hFFFF;
        c.symbol_kind = 8'hFF; c.node_id = 32'hA5A5_5A5A; queue_cmd(c);
        c.symbol_kind = 8'h01; c.node_id = 32'h7; queue_cmd(c);
        c = make_cmd(K_DECLARE); c.scope_index = 8'd1; c.name_id = 16'h0; queue_cmd(c);
        c = make_cmd(K_FIND); c.scope_index = 8'd1; c.name_id = 16'h0; queue_cmd(c);
        c = make_cmd(K_FIND); c.scope_index = 8'd0; queue_cmd(c);
        c = make_cmd(K_FIND); c.scope_index = 8'hFF; queue_cmd(c);
        c = make_cmd(K_SET_TYPE); c.candidate_index = 10'd1; c.type_value = 32'hFFFF_FFFF;
        queue_cmd(c);
        c = make_cmd(K_SET_SUPER); c.candidate_index = 10'd2; c.super_value = 32'hFFFF_FFFF;
        queue_cmd(c);
        c = make_cmd(K_SET_TYPE); queue_cmd(c);
        c = make_cmd(K_SET_SUPER); c.candidate_index = 10'h3FF; queue_cmd(c);
        c = make_cmd(K_OWNER); c.node_id = 32'hFFFF_FFFF; queue_cmd(c);
        c = make_cmd(K_NODE); c.node_id = 32'h7; queue_cmd(c);
        c = make_cmd(K_NODE); c.node_id = 32'h1234_5678; queue_cmd(c);
        c = make_cmd(K_RD_SCOPE); c.scope_index = 8'd3; queue_cmd(c);
        c = make_cmd(K_RD_SCOPE); c.scope_index = 8'hFF; queue_cmd(c);
        c = make_cmd(K_RD_SYM); c.symbol_index = 10'd1; queue_cmd(c);
        c = make_cmd(K_RD_SYM); c.symbol_index = 10'h3FF; queue_cmd(c);
        c = make_cmd(K_RD_CAND); c.candidate_index = 10'd1; queue_cmd(c);
        c = make_cmd(K_RD_CAND); c.candidate_index = 10'h3FF; queue_cmd(c);
        c = make_cmd(4'd15); queue_cmd(c);
        wait_drained();

        queue_random(300, 0);
        wait_drained();

        // fill the scope table past capacity
        queue_random(MAX_SCOPES - scopes_used + 4, 1);
        queue_random(150, 0);
        wait_drained();
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

/* scoped_symbol_table_unit.f */
rtl/core/sst_pkg.sv
rtl/core/sst_tables.sv
rtl/core/sst_ctrl.sv
rtl/core/scoped_symbol_table_unit.sv
tb/testbench.sv
